>>> src/lkr_pkg.sv
// ----------------------------------------------------------------------------
// lkr_pkg
// Shared types and constants of the LRU-K frame replacer: action and status
// codes, sequencer states, field widths and the scan control word.
// ----------------------------------------------------------------------------
package lkr_pkg;

    // Field widths fixed by the interface
    localparam int ACTION_W = 2;
    localparam int FRAME_W  = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 9;
    localparam int DEPTH_W  = 4;
    localparam int STAMP_W  = 32;
    localparam int ENTRY_W  = DEPTH_W + STAMP_W;

    // Configuration register map
    localparam int          APB_ADDR_W        = 3;
    localparam int          APB_DATA_W        = 32;
    localparam logic        REG_HISTORY_DEPTH = 1'b0;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACCESS    = 2'd0,
        ACT_SET_EVICT = 2'd1,
        ACT_REMOVE    = 2'd2,
        ACT_EVICT     = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_IGNORED = 2'd1,
        STATUS_REFUSED = 2'd2,
        STATUS_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_UPDATE,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_RESULT
    } state_t;

    // Control word from the sequencer to the oldest-stamp tracker
    typedef struct packed {
        logic clear;
        logic sample;
        logic eligible;
        logic mature;
    } scan_ctl_t;

endpackage

>>> src/lkr_apb_regs.sv
// ----------------------------------------------------------------------------
// lkr_apb_regs
// APB-style configuration port holding history_depth (K). A written zero is
// stored as one.
// ----------------------------------------------------------------------------
module lkr_apb_regs
    import lkr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DEPTH_W-1:0]    history_depth
);

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               hit;

    // Decode the single register
    assign hit = (paddr[2] == REG_HISTORY_DEPTH);

    always_comb
    begin
        depth_next = depth_reg;
        if (psel && penable && pwrite && hit)
        begin
            depth_next = (pwdata[DEPTH_W-1:0] == '0) ? DEPTH_MIN : pwdata[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // Read back the stored depth
    assign prdata        = hit ? {{(APB_DATA_W-DEPTH_W){1'b0}}, depth_reg} : '0;
    assign pready        = 1'b1;
    assign history_depth = depth_reg;

endmodule

>>> src/lkr_stamp_ram.sv
// ----------------------------------------------------------------------------
// lkr_stamp_ram
// Per-frame store of access count and order stamp: one write port, one
// read port with registered read data.
// ----------------------------------------------------------------------------
module lkr_stamp_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 36,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lkr_oldest_unit.sv
// ----------------------------------------------------------------------------
// lkr_oldest_unit
// Shared compare unit of the evict scan. Takes one frame a cycle and keeps
// the best candidate: any young frame beats any mature one, and within a
// group the lower stamp wins, ties to the earlier (lower) frame.
// ----------------------------------------------------------------------------
module lkr_oldest_unit
    import lkr_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctl_t          ctl,
    input  logic [IDX_W-1:0]   idx,
    input  logic [STAMP_W-1:0] stamp,
    output logic               found,
    output logic [IDX_W-1:0]   best_idx
);

    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic               best_mature_reg;
    logic               take;

    // Decide whether the incoming frame replaces the held candidate
    always_comb
    begin
        take = 1'b0;
        if (ctl.sample && ctl.eligible)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (!ctl.mature && best_mature_reg)
            begin
                take = 1'b1;
            end
            else if ((ctl.mature == best_mature_reg) && (stamp < best_stamp_reg))
            begin
                take = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    // Hold the candidate word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg    <= idx;
            best_stamp_reg  <= stamp;
            best_mature_reg <= ctl.mature;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule

>>> src/lru_k_frame_replacer_unit.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer_unit
// LRU-K replacer over FRAMES frames: record access, set evictable, remove
// and evict, one result word per input word.
// ----------------------------------------------------------------------------
// Set evictable, remove and ignored words pass from S_EXEC straight to S_RESULT;
// a record access of a tracked frame adds S_UPDATE (count read-modify-write through
// the stamp RAM) and evict adds S_SCAN, S_DRAIN and S_PICK, with the scan taking
// one frame a cycle. S_RESULT holds until the result channel is free.
// One word is in flight at a time; in_ready is high only when idle.
// Reset clears all frame marks, the access clock and the evictable total.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_unit
    import lkr_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ACTION_W-1:0]   action,
    input  logic [FRAME_W-1:0]    frame,
    input  logic                  new_evictable,
    // Result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [FRAME_W-1:0]    victim,
    output logic [TOTAL_W-1:0]    evictable_count,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int FW = $clog2(FRAMES);
    localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES - 1);

    state_t              state_reg, state_next;
    action_t             action_reg;
    logic [FW-1:0]       frame_reg;
    logic                range_reg;
    logic                mark_reg;
    logic [FRAMES-1:0]   valid_reg, valid_next;
    logic [FRAMES-1:0]   evict_reg, evict_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [STAMP_W-1:0]  clock_reg, clock_next;
    logic [FW-1:0]       scan_idx_reg, scan_idx_next;
    logic [FW-1:0]       rd_idx_reg;
    logic                rd_valid_reg;
    status_t             status_reg, status_next;
    logic [FW-1:0]       victim_reg, victim_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    status_t             out_status_reg;
    logic [FW-1:0]       out_victim_reg;
    logic [TOTAL_W-1:0]  out_count_reg;

    logic [DEPTH_W-1:0]  history_depth;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [FW-1:0]       ram_waddr;
    logic [FW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [DEPTH_W-1:0]  rd_count;
    logic [STAMP_W-1:0]  rd_stamp;
    logic [DEPTH_W-1:0]  new_count;
    scan_ctl_t           scan_ctl;
    logic                best_found;
    logic [FW-1:0]       best_idx;
    logic                accept;

    lkr_apb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .history_depth (history_depth)
    );

    lkr_stamp_ram #(
        .DEPTH  (FRAMES),
        .WIDTH  (ENTRY_W),
        .ADDR_W (FW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lkr_oldest_unit #(
        .IDX_W (FW)
    ) u_oldest (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .idx      (rd_idx_reg),
        .stamp    (rd_stamp),
        .found    (best_found),
        .best_idx (best_idx)
    );

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign rd_count  = ram_rdata[ENTRY_W-1:STAMP_W];
    assign rd_stamp  = ram_rdata[STAMP_W-1:0];
    assign new_count = (rd_count < history_depth) ? rd_count + DEPTH_W'(1) : rd_count;
    assign ram_raddr = (state_reg == S_SCAN) ? scan_idx_reg : frame_reg;
    assign ram_waddr = frame_reg;

    // Feed the compare unit with the frame read in the previous cycle
    always_comb
    begin
        scan_ctl.clear    = (state_reg == S_EXEC) && (action_reg == ACT_EVICT);
        scan_ctl.sample   = rd_valid_reg;
        scan_ctl.eligible = valid_reg[rd_idx_reg] && evict_reg[rd_idx_reg];
        scan_ctl.mature   = (rd_count >= history_depth);
    end

    // Sequencer: next state, frame marks, totals and result word
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        evict_next     = evict_reg;
        total_next     = total_reg;
        clock_next     = clock_reg;
        scan_idx_next  = scan_idx_reg;
        status_next    = status_reg;
        victim_next    = victim_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = {DEPTH_W'(1), clock_reg};

        // Drop a result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                victim_next = '0;
                status_next = STATUS_DONE;
                state_next  = S_RESULT;
                if (action_reg == ACT_EVICT)
                begin
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
                else if (!range_reg)
                begin
                    status_next = STATUS_IGNORED;
                end
                else
                begin
                    unique case (action_reg)
                        ACT_ACCESS:
                        begin
                            if (!valid_reg[frame_reg])
                            begin
                                // First access: count one, stamp now
                                ram_we                = 1'b1;
                                valid_next[frame_reg] = 1'b1;
                                evict_next[frame_reg] = 1'b0;
                                clock_next            = clock_reg + 32'd1;
                            end
                            else
                            begin
                                state_next = S_UPDATE;
                            end
                        end
                        ACT_SET_EVICT:
                        begin
                            if (!valid_reg[frame_reg])
                            begin
                                status_next = STATUS_IGNORED;
                            end
                            else if (evict_reg[frame_reg] != mark_reg)
                            begin
                                evict_next[frame_reg] = mark_reg;
                                total_next = mark_reg ? total_reg + TOTAL_W'(1)
                                                      : total_reg - TOTAL_W'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!valid_reg[frame_reg])
                            begin
                                status_next = STATUS_IGNORED;
                            end
                            else if (!evict_reg[frame_reg])
                            begin
                                status_next = STATUS_REFUSED;
                            end
                            else
                            begin
                                valid_next[frame_reg] = 1'b0;
                                evict_next[frame_reg] = 1'b0;
                                total_next            = total_reg - TOTAL_W'(1);
                            end
                        end
                        ACT_EVICT:
                        begin
                            status_next = STATUS_DONE;
                        end
                        default:
                        begin
                            status_next = STATUS_IGNORED;
                        end
                    endcase
                end
            end

            S_UPDATE:
            begin
                // Advance the count; restamp once mature
                ram_we     = 1'b1;
                ram_wdata  = {new_count, (new_count >= history_depth) ? clock_reg : rd_stamp};
                clock_next = clock_reg + 32'd1;
                state_next = S_RESULT;
            end

            S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + FW'(1);
                if (scan_idx_reg == LAST_FRAME)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_PICK;
            end

            S_PICK:
            begin
                if (best_found)
                begin
                    valid_next[best_idx] = 1'b0;
                    evict_next[best_idx] = 1'b0;
                    total_next           = total_reg - TOTAL_W'(1);
                    victim_next          = best_idx;
                    status_next          = STATUS_DONE;
                end
                else
                begin
                    victim_next = '0;
                    status_next = STATUS_EMPTY;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            evict_reg     <= '0;
            total_reg     <= '0;
            clock_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            evict_reg     <= evict_next;
            total_reg     <= total_next;
            clock_reg     <= clock_next;
            scan_idx_reg  <= scan_idx_next;
            rd_valid_reg  <= (state_reg == S_SCAN);
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_t'(action);
            frame_reg  <= frame[FW-1:0];
            range_reg  <= ({1'b0, frame} < (FRAME_W + 1)'(FRAMES));
            mark_reg   <= new_evictable;
        end
        rd_idx_reg  <= scan_idx_reg;
        status_reg  <= status_next;
        victim_reg  <= victim_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_victim_reg <= victim_reg;
            out_count_reg  <= total_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign victim          = FRAME_W'(out_victim_reg);
    assign evictable_count = out_count_reg;

    // Evictable total tracks the marked frames exactly
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == TOTAL_W'($countones(valid_reg & evict_reg)))
        else $error("evictable total out of step with frame marks");

    // Only tracked frames carry the evictable mark
    a_evict_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (evict_reg & ~valid_reg) == '0)
        else $error("evictable mark on untracked frame");

    // An accepted word leaves the idle state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("sequencer did not start on accepted word");

    // The chosen victim is an evictable tracked frame
    a_victim_eligible: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK && best_found) |-> (valid_reg[best_idx] && evict_reg[best_idx]))
        else $error("scan picked an ineligible frame");

endmodule
